// ===== rtl/itoa_pkg.sv =====
// Shared constants, types and helper functions for the integer-to-text block.
// No dependencies; every other file in rtl/ imports this package.
package itoa_pkg;

  // Width of the integer being converted
  localparam int VALUE_BITS  = 32;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 8;
  // Digit store index and digit count (binary gives up to VALUE_BITS digits)
  localparam int IDX_W       = $clog2(VALUE_BITS);
  localparam int CNT_W       = $clog2(VALUE_BITS + 1);
  localparam int STEP_W      = $clog2(VALUE_BITS);
  // Job queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_W-1:0] DECIMAL  = 6'd10;

  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LETTER = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;

  // One classified conversion job
  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    logic [BASE_W-1:0]     base;
    logic                  neg;
  } itoa_job_t;

  // Map a digit value 0..35 to '0'..'9', 'a'..'z'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d < DECIMAL) begin
      return CH_ZERO + d_ext;
    end else begin
      return CH_LETTER + d_ext - CHAR_W'(DECIMAL);
    end
  endfunction

endpackage

// ===== rtl/itoa_front.sv =====
// Front end: clamps the base into 2..36 and decides sign and magnitude.
// Depends on itoa_pkg.
module itoa_front import itoa_pkg::*; (
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic        [BASE_W-1:0]     base,
  output itoa_job_t                    job
);

  logic [BASE_W-1:0]     base_sat;
  logic [VALUE_BITS-1:0] raw;
  logic                  neg;

  // Saturate the base into the legal range
  always_comb begin
    if (base < BASE_MIN) begin
      base_sat = BASE_MIN;
    end else if (base > BASE_MAX) begin
      base_sat = BASE_MAX;
    end else begin
      base_sat = base;
    end
  end

  // Sign only in decimal; other bases read the raw bit pattern
  assign raw = value;
  assign neg = (base_sat == DECIMAL) && raw[VALUE_BITS-1];

  assign job.mag  = neg ? (~raw + VALUE_BITS'(1)) : raw;
  assign job.base = base_sat;
  assign job.neg  = neg;

endmodule

// ===== rtl/itoa_queue.sv =====
// Short job queue between front end and conversion engine.
// Depends on itoa_pkg (itoa_job_t, QUEUE_DEPTH).
module itoa_queue import itoa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  itoa_job_t job_in,
  output logic      full,
  input  logic      pop,
  output itoa_job_t job_out,
  output logic      empty
);

  itoa_job_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign job_out = entries[rd_ptr];

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/itoa_back.sv =====
// Conversion engine: restoring divider (one quotient bit per cycle), digit
// store, and character output register. Depends on itoa_pkg.
module itoa_back import itoa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  itoa_job_t         job,
  input  logic              job_empty,
  output logic              job_pop,
  output logic              empty,
  input  logic              pop,
  output logic [CHAR_W-1:0] character,
  output logic              last
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIVIDE = 5'b00010,
    ST_SIGN   = 5'b00100,
    ST_READ   = 5'b01000,
    ST_WRITE  = 5'b10000
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] quo;
  logic [BASE_W-1:0]     rem;
  logic [BASE_W-1:0]     base_r;
  logic                  neg;
  logic [STEP_W-1:0]     step;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      rd_idx;
  logic [CHAR_W-1:0]     rd_data;
  logic [CHAR_W-1:0]     store [VALUE_BITS];
  logic                  out_valid;

  logic [BASE_W:0]       r_shift;
  logic [BASE_W:0]       diff;
  logic                  fit;
  logic [BASE_W-1:0]     rem_next;
  logic [VALUE_BITS-1:0] quo_next;
  logic                  step_last;
  logic                  digit_wr;
  logic                  out_free;
  logic                  out_load;

  // One restoring divide step
  assign r_shift   = {rem, quo[VALUE_BITS-1]};
  assign fit       = (r_shift >= {1'b0, base_r});
  assign diff      = r_shift - {1'b0, base_r};
  assign rem_next  = fit ? diff[BASE_W-1:0] : r_shift[BASE_W-1:0];
  assign quo_next  = {quo[VALUE_BITS-2:0], fit};
  assign step_last = (step == STEP_W'(VALUE_BITS - 1));
  assign digit_wr  = (state == ST_DIVIDE) && step_last;

  assign job_pop   = (state == ST_IDLE) && !job_empty;
  assign out_free  = !out_valid || pop;
  assign out_load  = ((state == ST_SIGN) || (state == ST_WRITE)) && out_free;
  assign empty     = !out_valid;

  // Digit store: write the finished digit, read registered
  always_ff @(posedge clk) begin
    if (digit_wr) begin
      store[count[IDX_W-1:0]] <= digit_char(rem_next);
    end
    rd_data <= store[rd_idx];
  end

  // Sequence divide, sign and digit output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      step      <= '0;
      rd_idx    <= '0;
    end else begin
      // Show a newly loaded character; drop the shown one once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            quo    <= job.mag;
            base_r <= job.base;
            neg    <= job.neg;
            rem    <= '0;
            step   <= '0;
            count  <= '0;
            state  <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          quo <= quo_next;
          if (step_last) begin
            // Digit done: restart on the quotient or go emit
            rem    <= '0;
            step   <= '0;
            count  <= count + CNT_W'(1);
            rd_idx <= count[IDX_W-1:0];
            if (quo_next == '0) begin
              state <= neg ? ST_SIGN : ST_READ;
            end
          end else begin
            rem  <= rem_next;
            step <= step + STEP_W'(1);
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            character <= CH_MINUS;
            last      <= 1'b0;
            state     <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (out_free) begin
            character <= rd_data;
            last      <= (rd_idx == '0);
            if (rd_idx == '0) begin
              state <= ST_IDLE;
            end else begin
              rd_idx <= rd_idx - IDX_W'(1);
              state  <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/integer_to_text_any_base_top.sv =====
// Top level of the integer-to-text converter: front end, job queue and
// conversion engine. Depends on itoa_pkg, itoa_front, itoa_queue, itoa_back.
//
// Usage:
//   Input side is a queue: drive value and base with push; a transaction
//   happens on a clock edge with push high and full low. Base is clamped into
//   2..36. Decimal negatives get a leading '-'; other bases print the raw
//   two's complement pattern as unsigned.
//   Output side is a queue: while empty is low, character and last show the
//   oldest character; pop high at a clock edge takes it. last marks the final
//   character of each number, most significant digit first.
//   Engine: each digit comes from the bit-serial restoring divider, the sign
//   is loaded straight into the output register and each digit passes through
//   the registered digit store read (ST_READ, then ST_WRITE). After the last
//   character is loaded the engine returns to ST_IDLE and takes the next job.
//   Items are converted one at a time; a two-entry job queue takes new items
//   while the engine works or waits. When the receiver stalls, the output
//   register holds and the engine waits; full rises once the queue fills.
//   Reset (rst, synchronous) empties the queue and the output register.
module integer_to_text_any_base_top import itoa_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic        [BASE_W-1:0]     base,
  output logic                         empty,
  input  logic                         pop,
  output logic        [CHAR_W-1:0]     character,
  output logic                         last
);

  itoa_job_t front_job;
  itoa_job_t q_job;
  logic      q_empty;
  logic      q_pop;

  itoa_front u_front (
    .value (value),
    .base  (base),
    .job   (front_job)
  );

  itoa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (front_job),
    .full    (full),
    .pop     (q_pop),
    .job_out (q_job),
    .empty   (q_empty)
  );

  itoa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .last      (last)
  );

  // Engine never pulls a job from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job pulled from empty queue");

  // Only digit, letter or minus characters are shown
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((character >= 8'h30 && character <= 8'h39) ||
                (character >= 8'h61 && character <= 8'h7a) ||
                character == CH_MINUS))
    else $error("illegal character on output");

  // A sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && character == CH_MINUS) |-> !last)
    else $error("minus sign flagged as last");

  // Output stays empty in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("output not empty after reset");

endmodule
